>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/gcd_pkg.sv
`timescale 1ns / 1ps
package gcd_pkg;

  // Input angle format: degrees with FRAC_BITS fraction bits
  localparam int FRAC_BITS = 16;
  localparam int ITERS     = 30;   // CORDIC iterations
  localparam int CW        = 34;   // CORDIC datapath width (Q30 plus headroom)
  localparam int ANG_W     = 26;   // angle width after forming lon difference
  localparam int MAG_W     = 23;   // folded angle magnitude, up to 90 degrees
  localparam int Q_W       = 18;   // magnitude / 45
  localparam int PROD_W    = 50;   // q * pi

  localparam logic signed [ANG_W-1:0] FULL_A    = ANG_W'(360 << FRAC_BITS);
  localparam logic signed [ANG_W-1:0] HALF_A    = ANG_W'(180 << FRAC_BITS);
  localparam logic signed [ANG_W-1:0] QUARTER_A = ANG_W'(90 << FRAC_BITS);

  // 180 degrees = 45 * 2^18 at 16 fraction bits; divide by 45 via reciprocal
  localparam int               RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] RECIP45 = 24'd11930465;
  localparam int               RECIP_SH  = 29;
  localparam int               HALF_SH   = 18;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_CW    = 34'sd3373259426;
  localparam logic signed [31:0]   ONE_Q30  = 32'sd1073741824;

  localparam logic [31:0] ATAN_Q30 [ITERS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

  // Remainder table: floor((r * pi + quarter) / 45) for r = mag mod 45
  localparam int UT_N = 64;
  typedef logic [31:0] utab_t [UT_N];

  function automatic utab_t build_utab();
    utab_t t;
    for (int i = 0; i < UT_N; i++) begin
      t[i] = 32'((64'(i) * 64'(PI_Q30) + 64'(90 << FRAC_BITS)) / 64'd45);
    end
    return t;
  endfunction

  localparam utab_t UTAB = build_utab();

  // Square root
  localparam int SQ_STEPS = ITERS + 1;
  localparam int NW       = 62;

  // Radius and distance
  localparam int                 RADIUS_W     = 24;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1630976;
  localparam int                 DIST_W       = 26;
  localparam logic [DIST_W-1:0]  DIST_MAX     = 26'd67108863;
  localparam logic [DIST_W-1:0]  DIST_BOUND   = 26'd52707178;

  // Pipeline depths
  localparam int ANG_LAT  = 5 + ITERS + 1;
  localparam int ACOS_LAT = 2 * ITERS + 4;
  localparam int LAT      = ANG_LAT + 4 + ACOS_LAT + 2;

endpackage

>>> rtl/gcd_if.sv
`timescale 1ns / 1ps
// Point-pair channel
interface gcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] first_lat;
  logic signed [24:0] first_lon;
  logic signed [23:0] second_lat;
  logic signed [24:0] second_lon;

  modport source (output valid, first_lat, first_lon, second_lat, second_lon,
                  input ready);
  modport sink   (input valid, first_lat, first_lon, second_lat, second_lon,
                  output ready);
endinterface

// Distance channel
interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

>>> rtl/gcd_sincos.sv
`timescale 1ns / 1ps
// Angle in degrees to sin/cos in Q30: reduce, fold, convert, 30 CORDIC stages.
module gcd_sincos import gcd_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang,
  output logic signed [CW-1:0]    sin_o,
  output logic signed [CW-1:0]    cos_o
);

  // S1: wrap into [-180, 180)
  logic signed [ANG_W-1:0] r1_nxt, r1_r;
  always_comb begin
    if (ang >= HALF_A) begin
      r1_nxt = ang - FULL_A;
    end else if (ang < -HALF_A) begin
      r1_nxt = ang + FULL_A;
    end else begin
      r1_nxt = ang;
    end
  end

  // S2: fold to [-90, 90], take magnitude
  logic signed [ANG_W-1:0] r2;
  logic                    flip2_nxt, negz2_nxt;
  logic [MAG_W-1:0]        mag2_nxt, mag2_r;
  logic                    flip2_r, negz2_r;
  always_comb begin
    flip2_nxt = 1'b0;
    if (r1_r > QUARTER_A) begin
      r2        = HALF_A - r1_r;
      flip2_nxt = 1'b1;
    end else if (r1_r < -QUARTER_A) begin
      r2        = -HALF_A - r1_r;
      flip2_nxt = 1'b1;
    end else begin
      r2 = r1_r;
    end
    negz2_nxt = r2[ANG_W-1];
    mag2_nxt  = negz2_nxt ? MAG_W'(-r2) : MAG_W'(r2);
  end

  // S3: q = mag / 45 by reciprocal
  logic [MAG_W+RECIP_W-1:0] qp;
  logic [Q_W-1:0]           q3_r;
  logic [MAG_W-1:0]         mag3_r;
  logic                     flip3_r, negz3_r;
  assign qp = mag2_r * RECIP45;

  // S4: q * pi and remainder table
  logic [MAG_W-1:0]  rm_full;
  logic [5:0]        rm;
  logic [PROD_W-1:0] prod4_nxt, prod4_r;
  logic [31:0]       u4_r;
  logic              flip4_r, negz4_r;
  assign rm_full   = mag3_r - MAG_W'(q3_r) * MAG_W'(45);
  assign rm        = rm_full[5:0];
  assign prod4_nxt = q3_r * PI_Q30;

  // S5: radians in Q30, sign restored
  logic [PROD_W:0]          sum5;
  logic [30:0]              t5;
  logic signed [CW-1:0]     tz;
  assign sum5 = {1'b0, prod4_r} + (PROD_W+1)'(u4_r);
  assign t5   = sum5[HALF_SH+30:HALF_SH];
  assign tz   = signed'(CW'(t5));

  logic signed [CW-1:0] x_r [ITERS+1];
  logic signed [CW-1:0] y_r [ITERS+1];
  logic signed [CW-1:0] z_r [ITERS+1];
  logic [ITERS:0]       fl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r    <= r1_nxt;
      mag2_r  <= mag2_nxt;
      flip2_r <= flip2_nxt;
      negz2_r <= negz2_nxt;
      q3_r    <= qp[MAG_W+RECIP_W-1:RECIP_SH];
      mag3_r  <= mag2_r;
      flip3_r <= flip2_r;
      negz3_r <= negz2_r;
      prod4_r <= prod4_nxt;
      u4_r    <= UTAB[rm];
      flip4_r <= flip3_r;
      negz4_r <= negz3_r;
      x_r[0]  <= GAIN_Q30;
      y_r[0]  <= '0;
      z_r[0]  <= negz4_r ? -tz : tz;
      fl_r[0] <= flip4_r;
    end
  end

  // Rotation CORDIC, one iteration per stage
  for (genvar i = 0; i < ITERS; i++) begin : g_rot
    localparam logic signed [CW-1:0] AT = signed'(CW'(ATAN_Q30[i]));
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[i+1] <= fl_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - AT;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + AT;
        end
      end
    end
  end

  // Output: cos negated for folded angles
  logic signed [CW-1:0] sin_r, cos_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= y_r[ITERS];
      cos_r <= fl_r[ITERS] ? -x_r[ITERS] : x_r[ITERS];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> rtl/gcd_acos.sv
`timescale 1ns / 1ps
// acos in Q30: s = isqrt(1 - c^2) one bit per stage, then vectoring CORDIC.
module gcd_acos import gcd_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] c_i,
  input  logic [NW-1:0]      csq_i,
  output logic [31:0]        theta_o
);

  // A1: radicand and |c|
  logic [NW-1:0] n_r  [SQ_STEPS+1];
  logic [NW-1:0] r_r  [SQ_STEPS+1];
  logic [30:0]   xa_r [SQ_STEPS+1];
  logic [SQ_STEPS:0] ng_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]  <= (NW'(1) << 60) - csq_i;
      r_r[0]  <= '0;
      xa_r[0] <= c_i[31] ? 31'(-c_i) : 31'(c_i);
      ng_r[0] <= c_i[31];
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [NW-1:0] tr;
    assign tr = r_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        xa_r[k+1] <= xa_r[k];
        ng_r[k+1] <= ng_r[k];
        if (n_r[k] >= tr) begin
          n_r[k+1] <= n_r[k] - tr;
          r_r[k+1] <= (r_r[k] >> 1) + BIT;
        end else begin
          n_r[k+1] <= n_r[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
      end
    end
  end

  // Vectoring CORDIC on (|c|, s)
  logic signed [CW-1:0] vx_r [ITERS+1];
  logic signed [CW-1:0] vy_r [ITERS+1];
  logic signed [CW-1:0] vz_r [ITERS+1];
  logic [ITERS:0]       vn_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= signed'(CW'(xa_r[SQ_STEPS]));
      vy_r[0] <= signed'(CW'(r_r[SQ_STEPS]));
      vz_r[0] <= '0;
      vn_r[0] <= ng_r[SQ_STEPS];
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_vec
    localparam logic signed [CW-1:0] AT = signed'(CW'(ATAN_Q30[i]));
    logic signed [CW-1:0] dx, dy;
    assign dx = vy_r[i] >>> i;
    assign dy = vx_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        vn_r[i+1] <= vn_r[i];
        if (!vy_r[i][CW-1]) begin
          vx_r[i+1] <= vx_r[i] + dx;
          vy_r[i+1] <= vy_r[i] - dy;
          vz_r[i+1] <= vz_r[i] + AT;
        end else begin
          vx_r[i+1] <= vx_r[i] - dx;
          vy_r[i+1] <= vy_r[i] + dy;
          vz_r[i+1] <= vz_r[i] - AT;
        end
      end
    end
  end

  // Quadrant fix for negative c, clamp to [0, pi]
  logic signed [CW-1:0] th;
  logic [31:0]          theta_nxt, theta_r;
  always_comb begin
    th = vn_r[ITERS] ? (PI_CW - vz_r[ITERS]) : vz_r[ITERS];
    if (th[CW-1]) begin
      theta_nxt = '0;
    end else if (th > PI_CW) begin
      theta_nxt = PI_Q30;
    end else begin
      theta_nxt = th[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= theta_nxt;
    end
  end

  assign theta_o = theta_r;

endmodule

>>> rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload                                          Handshake
// in_ch      in   first_lat, first_lon, second_lat, second_lon     valid/ready
// out_ch     out  distance (1/256 km)                              valid/ready
// cfg        in   cfg_data = sphere radius (1/256 km)              cfg_we
//
// One item per cycle sustained while the output is not stalled; the pipeline runs
// through the two 30-stage CORDIC pipelines and the 31-stage square root.
// Reset (rst_n, synchronous) clears the valid bits and loads the radius
// with 6371 km.
// A result held at the output freezes the whole pipeline; in_ch.ready
// drops for exactly those cycles and nothing is lost or repeated.
module great_circle_distance import gcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  gcd_in_if.sink              in_ch,
  gcd_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_data
);

`include "assert_macros.svh"

  // Pipeline advance and valid chain
  logic [LAT-1:0] v_r;
  logic           adv;
  assign adv         = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid && adv};
    end
  end

  // Radius register
  logic [RADIUS_W-1:0] rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      rad_r <= cfg_data;
    end
  end

  // Three angle lanes: lat1, lat2, lon2 - lon1
  logic signed [ANG_W-1:0] a_lat1, a_lat2, a_dlon;
  assign a_lat1 = {{(ANG_W-24){in_ch.first_lat[23]}}, in_ch.first_lat};
  assign a_lat2 = {{(ANG_W-24){in_ch.second_lat[23]}}, in_ch.second_lat};
  assign a_dlon = {in_ch.second_lon[24], in_ch.second_lon}
                - {in_ch.first_lon[24], in_ch.first_lon};

  logic signed [CW-1:0] s1, c1, s2, c2, cd;

  gcd_sincos u_lat1 (.clk(clk), .en(adv), .ang(a_lat1), .sin_o(s1), .cos_o(c1));
  gcd_sincos u_lat2 (.clk(clk), .en(adv), .ang(a_lat2), .sin_o(s2), .cos_o(c2));
  gcd_sincos u_dlon (.clk(clk), .en(adv), .ang(a_dlon), .sin_o(), .cos_o(cd));

  // M1: sin products and cos products
  logic signed [31:0] s1n, s2n, c1n, c2n;
  logic signed [63:0] pss_nxt, pcc_nxt, pss1_r, pcc1_r;
  logic signed [31:0] cd1_r;
  assign s1n = s1[31:0];
  assign s2n = s2[31:0];
  assign c1n = c1[31:0];
  assign c2n = c2[31:0];
  assign pss_nxt = s1n * s2n;
  assign pcc_nxt = c1n * c2n;

  // M2: scale cos product by cos of longitude difference
  logic signed [33:0] pcc_sh;
  logic signed [63:0] t_nxt, t2_r, pss2_r;
  assign pcc_sh = pcc1_r[63:30];
  assign t_nxt  = pcc_sh * cd1_r;

  // M3: sum, scale, clamp to [-1, 1]
  logic signed [63:0] sum3;
  logic signed [33:0] csh;
  logic signed [31:0] c_nxt, c3_r;
  assign sum3 = pss2_r + t2_r;
  assign csh  = sum3[63:30];
  always_comb begin
    if (csh > 34'sd1073741824) begin
      c_nxt = ONE_Q30;
    end else if (csh < -34'sd1073741824) begin
      c_nxt = -ONE_Q30;
    end else begin
      c_nxt = csh[31:0];
    end
  end

  // M4: c squared
  logic signed [63:0] csq_nxt;
  logic [NW-1:0]      csq4_r;
  logic signed [31:0] c4_r;
  assign csq_nxt = c3_r * c3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pss1_r <= pss_nxt;
      pcc1_r <= pcc_nxt;
      cd1_r  <= cd[31:0];
      pss2_r <= pss1_r;
      t2_r   <= t_nxt;
      c3_r   <= c_nxt;
      csq4_r <= csq_nxt[NW-1:0];
      c4_r   <= c3_r;
    end
  end

  logic [31:0] theta;
  gcd_acos u_acos (.clk(clk), .en(adv), .c_i(c4_r), .csq_i(csq4_r), .theta_o(theta));

  // D1: theta * radius; D2: round, saturate
  logic [55:0]        prod_r;
  logic [56:0]        rnd;
  logic [DIST_W-1:0]  dist_nxt, dist_r;
  assign rnd = {1'b0, prod_r} + (57'(1) << 29);
  always_comb begin
    if (rnd[56:30] > 27'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = rnd[30+DIST_W-1:30];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= theta * rad_r;
      dist_r <= dist_nxt;
    end
  end

  assign out_ch.valid    = v_r[LAT-1];
  assign out_ch.distance = dist_r;

  // Checks
  `ASSERT_IMPL(a_dist_bound, clk, rst_n, out_ch.valid, out_ch.distance <= DIST_BOUND)
  `ASSERT_IMPL(a_ready_stall, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready)
  `ASSERT_NEXT(a_pipe_frozen, clk, rst_n, out_ch.valid && !out_ch.ready, $stable(v_r))

endmodule

>>> tb/great_circle_distance_tb.sv
`timescale 1ns / 1ps
module great_circle_distance_tb;
  import gcd_pkg::*;

  localparam int  N_RANDOM    = 500;
  localparam int  DRAIN       = LAT + 20;
  localparam longint MAX_CYC  = 600000;
  localparam longint Q30_ONE  = 64'sd1073741824;

  // Deg * 2^16 reference points
  localparam int DEG = 65536;

  typedef struct packed {
    logic signed [23:0] lat1;
    logic signed [24:0] lon1;
    logic signed [23:0] lat2;
    logic signed [24:0] lon2;
  } pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RADIUS_W-1:0] cfg_data;

  gcd_in_if  pts ();
  gcd_out_if dst ();

  great_circle_distance dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pts.sink),
    .out_ch   (dst.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Radius as the testbench believes it is set
  logic [RADIUS_W-1:0] cur_radius;
  logic [DIST_W-1:0]   dist_fifo[$];
  int                  n_errors;
  longint              n_cycles;
  bit                  burst_mode;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floor integer square root of a 64-bit value
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotation CORDIC sine and cosine (Q30) of an angle in degrees * 2^16
  function automatic void rotate_angle(input longint a, output longint sn, output longint cs);
    longint full_d;
    longint half_d;
    longint quart_d;
    longint r;
    longint mag;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    full_d  = longint'(360) << FRAC_BITS;
    half_d  = longint'(180) << FRAC_BITS;
    quart_d = longint'(90) << FRAC_BITS;
    flip = 1'b0;
    r = a % full_d;
    if (r >= half_d) r = r - full_d;
    if (r < -half_d) r = r + full_d;
    // fold into [-90,90]; cosine flips sign
    if (r > quart_d) begin
      r = half_d - r;
      flip = 1'b1;
    end else if (r < -quart_d) begin
      r = -half_d - r;
      flip = 1'b1;
    end
    mag = (r < 0) ? -r : r;
    z = (mag * longint'(PI_Q30) + quart_d) / half_d;
    if (r < 0) z = -z;
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endfunction

  // Arccosine (Q30 radians) via vectoring CORDIC on (|c|, sqrt(1-c^2))
  function automatic longint arc_cosine(longint c);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = (c < 0) ? -c : c;
    y = longint'(int_sqrt(longint'(Q30_ONE * Q30_ONE) - c * c));
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
      end
    end
    return (c < 0) ? longint'(PI_Q30) - z : z;
  endfunction

  // Expected distance for one point pair at the given radius
  function automatic logic [DIST_W-1:0] calc_distance(pair_t p, logic [RADIUS_W-1:0] rad);
    longint s1, c1, s2, c2, sd, cd;
    longint sum;
    longint c;
    longint theta;
    longint unsigned d;
    rotate_angle(longint'(p.lat1), s1, c1);
    rotate_angle(longint'(p.lat2), s2, c2);
    rotate_angle(longint'(p.lon2) - longint'(p.lon1), sd, cd);
    sum = s1 * s2 + ((c1 * c2) >>> 30) * cd;
    c = sum >>> 30;
    if (c > Q30_ONE) c = Q30_ONE;
    if (c < -Q30_ONE) c = -Q30_ONE;
    theta = arc_cosine(c);
    if (theta < 0) theta = 0;
    if (theta > longint'(PI_Q30)) theta = longint'(PI_Q30);
    d = (longint'(theta) * longint'(rad) + (longint'(1) << 29)) >> 30;
    if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
    return d[DIST_W-1:0];
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Expected results are queued on each accepted input transfer
  always @(posedge clk) begin
    if (rst_n && pts.valid && pts.ready) begin
      dist_fifo.push_back(calc_distance({pts.first_lat, pts.first_lon,
                                         pts.second_lat, pts.second_lon}, cur_radius));
    end
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && dst.valid && dst.ready) begin
      if (dist_fifo.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected distance %0d", dst.distance);
      end else begin
        logic [DIST_W-1:0] want;
        want = dist_fifo.pop_front();
        if (dst.distance !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("distance mismatch: expected %0d, got %0d", want, dst.distance);
        end
      end
    end
  end

  // Output back-pressure
  initial begin
    dst.ready <= 1'b0;
    forever begin
      int g;
      @(posedge clk);
      g = pick_gap();
      if (g == 0) begin
        dst.ready <= 1'b1;
      end else begin
        dst.ready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end
    end
  end

  // Run limit
  initial begin
    n_cycles = 0;
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > MAX_CYC) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drive one pair and hold it until the transfer happens
  task automatic send_pair(pair_t p);
    int g;
    pts.valid      <= 1'b1;
    pts.first_lat  <= p.lat1;
    pts.first_lon  <= p.lon1;
    pts.second_lat <= p.lat2;
    pts.second_lon <= p.lon2;
    do @(posedge clk); while (!pts.ready);
    g = pick_gap();
    if (g > 0) begin
      pts.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Block must be idle before a radius write
  task automatic drain_pipe();
    pts.valid <= 1'b0;
    @(posedge clk);
    while (dist_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cur_radius = r;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    if ($urandom_range(0, 9) < 8) begin
      // well-formed coordinates
      p.lat1 = $signed($urandom_range(0, 2 * 5898240)) - 24'sd5898240;
      p.lat2 = $signed($urandom_range(0, 2 * 5898240)) - 24'sd5898240;
      p.lon1 = $signed($urandom_range(0, 2 * 11796480)) - 25'sd11796480;
      p.lon2 = $signed($urandom_range(0, 2 * 11796480)) - 25'sd11796480;
      // some nearby point pairs
      if ($urandom_range(0, 3) == 0) begin
        p.lat2 = p.lat1 + $signed(24'($urandom_range(0, 2000)) - 24'sd1000);
        p.lon2 = p.lon1 + $signed(25'($urandom_range(0, 2000)) - 25'sd1000);
      end
    end else begin
      // any bit pattern the fields allow
      p.lat1 = $urandom;
      p.lon1 = $urandom;
      p.lat2 = $urandom;
      p.lon2 = $urandom;
    end
    return p;
  endfunction

  // Directed pairs: poles, antipodes, date line, field extremes, wrap
  pair_t edge_pairs[] = '{
    '{24'sd0, 25'sd0, 24'sd0, 25'sd0},
    '{24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd11796480},
    '{24'sd0, -25'sd11796480, 24'sd0, 25'sd11796480},
    '{24'sd2000000, 25'sd3000000, -24'sd2000000, -25'sd8796480},
    '{24'sd5898240, 25'sd11796480, 24'sd5898240, -25'sd11796480},
    '{24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000},
    '{24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF},
    '{24'sh7FFFFF, 25'sh1000000, 24'sh7FFFFF, 25'sh1000000},
    '{24'sd6000000, 25'sd0, 24'sd5796480, 25'sd11796480},
    '{24'sd0, 25'sd12000000, 24'sd0, -25'sd11592960},
    '{24'sd3342336, 25'sd150, 24'sd3342336, 25'sd151},
    '{-24'sd1, -25'sd1, 24'sd1, 25'sd1},
    '{24'sd2949120, 25'sd0, 24'sd2949120, 25'sd5898240},
    '{-24'sd5898239, 25'sd7000000, 24'sd5898239, -25'sd4796480}
  };

  logic [RADIUS_W-1:0] radii[4];

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;
    pts.valid      <= 1'b0;
    pts.first_lat  <= '0;
    pts.first_lon  <= '0;
    pts.second_lat <= '0;
    pts.second_lon <= '0;
    cur_radius     = RADIUS_RESET;
    n_errors       = 0;
    burst_mode     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset radius
    foreach (edge_pairs[i]) send_pair(edge_pairs[i]);
    drain_pipe();

    radii[0] = 24'd16777215;
    radii[1] = 24'd1;
    radii[2] = 24'($urandom_range(1, 16777215));
    radii[3] = RADIUS_RESET;
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      if (ph < 2) foreach (edge_pairs[i]) send_pair(edge_pairs[i]);
      for (int k = 0; k < N_RANDOM / 4; k++) begin
        if (k % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        send_pair(rand_pair());
      end
      burst_mode = 1'b0;
      drain_pipe();
    end

    if (n_errors == 0 && dist_fifo.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
